@@ rtl/assert_macros.svh @@
// Assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dpdc_pkg.sv @@
package dpdc_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int COUNT_WIDTH = 3;
	localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
	localparam int SQ_WIDTH    = 2 * VALUE_WIDTH + 2;
	localparam int DIV_WIDTH   = VALUE_WIDTH + 1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

@@ rtl/distinct_prime_divisor_counter_unit.sv @@
// channel   | ports                   | handshake
// ----------+-------------------------+---------------------------------
// in beat   | n_value                 | start high while busy low
// out beat  | divisor_count           | done high for one cycle, no stall
//
// Per candidate d (while d*d <= n): a check, a restoring division of n by d in the
// divide state and an evaluate; a found factor is divided out again, divide and
// evaluate repeating. For n below 4 the first check fails and goes straight to done.
// busy stays high from the accepting edge through the done cycle.
// Reset clears the sequencer; done is shown once, divisor_count holds until the next accept.
module distinct_prime_divisor_counter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	output logic                                 done,
	input  logic [dpdc_pkg::VALUE_WIDTH-1:0]     n_value,
	output logic [dpdc_pkg::COUNT_WIDTH-1:0]     divisor_count
);
	import dpdc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [VALUE_WIDTH-1:0]  n_q;
	logic [DIV_WIDTH-1:0]    d_q;
	logic [SQ_WIDTH-1:0]     sq_q;
	logic [DIV_WIDTH-1:0]    rem_q;
	logic [VALUE_WIDTH-1:0]  dvd_q;
	logic [STEP_WIDTH-1:0]   step_q;
	logic [COUNT_WIDTH-1:0]  cnt_q;
	logic                    hit_q;

	logic [DIV_WIDTH:0]      trial;
	logic [DIV_WIDTH:0]      diff;
	logic                    fits;
	logic                    sq_ok;
	logic [COUNT_WIDTH-1:0]  cnt_inc;

	assign trial   = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign diff    = trial - {1'b0, d_q};
	assign fits    = !diff[DIV_WIDTH];
	assign sq_ok   = sq_q <= SQ_WIDTH'(n_q);
	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_DONE);
	assign divisor_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q <= '0;
					if (sq_ok) begin
						state_q <= ST_DIV;
					end else begin
						if (n_q > VALUE_WIDTH'(1)) cnt_q <= cnt_inc;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_WIDTH'(VALUE_WIDTH - 1)) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					step_q <= '0;
					if (rem_q == '0) begin
						if (!hit_q) cnt_q <= cnt_inc;
						hit_q   <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						hit_q   <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q  <= n_value;
				d_q  <= DIV_WIDTH'(2);
				sq_q <= SQ_WIDTH'(4);
			end
			ST_CHECK: begin
				rem_q <= '0;
				dvd_q <= n_q;
			end
			ST_DIV: begin
				if (fits) begin
					rem_q <= diff[DIV_WIDTH-1:0];
				end else begin
					rem_q <= trial[DIV_WIDTH-1:0];
				end
				dvd_q <= {dvd_q[VALUE_WIDTH-2:0], fits};
			end
			ST_EVAL: begin
				if (rem_q == '0) begin
					n_q   <= dvd_q;
					rem_q <= '0;
				end else begin
					d_q  <= d_q + 1'b1;
					sq_q <= sq_q + SQ_WIDTH'({d_q, 1'b1});
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/dpdc_chk.sv @@
`include "assert_macros.svh"

module dpdc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [dpdc_pkg::VALUE_WIDTH-1:0]  n_value,
	input logic [dpdc_pkg::COUNT_WIDTH-1:0]  divisor_count
);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "no busy after accept")
	`ASSERT_SAME(a_done_busy, clk, arst_n, done, busy, "done shown while idle")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy, "done not a single beat")
	`ASSERT_SAME(a_fall_done, clk, arst_n, $fell(busy), $past(done), "busy dropped without done")

endmodule

bind distinct_prime_divisor_counter_unit dpdc_chk u_dpdc_chk (.*);

@@ tb/prime_count_watch.sv @@
`timescale 1ns / 1ps

module prime_count_watch (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             done,
	input  logic [dpdc_pkg::VALUE_WIDTH-1:0] n_value,
	input  logic [dpdc_pkg::COUNT_WIDTH-1:0] divisor_count,
	output int                               mismatches,
	output int                               waiting
);
	import dpdc_pkg::*;

	typedef struct {
		logic [VALUE_WIDTH-1:0] number;
		logic [COUNT_WIDTH-1:0] count;
	} count_due_t;

	count_due_t counts_due[$];

	function automatic logic [COUNT_WIDTH-1:0] distinct_prime_total(
		input logic [VALUE_WIDTH-1:0] value
	);
		longint unsigned rest;
		longint unsigned trial;
		int unsigned     total;
		rest  = value;
		total = 0;
		if (rest < 2)
			return '0;
		for (trial = 2; trial * trial <= rest; trial++) begin
			if (rest % trial == 0) begin
				total++;
				while (rest % trial == 0)
					rest = rest / trial;
			end
		end
		if (rest > 1)
			total++;
		if (total > COUNT_MAX)
			return COUNT_MAX;
		return total[COUNT_WIDTH-1:0];
	endfunction

	task automatic report(input string text);
		$display("%0t: %s", $realtime, text);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		waiting    = 0;
	end

	always @(posedge clk) begin
		count_due_t head;
		if (arst_n) begin
			if (start === 1'b1 && busy === 1'b0)
				counts_due.push_back('{n_value, distinct_prime_total(n_value)});
			if (done === 1'b1) begin
				if (counts_due.size() == 0) begin
					report($sformatf("divisor_count %0d with no beat pending", divisor_count));
				end else begin
					head = counts_due.pop_front();
					if (divisor_count !== head.count)
						report($sformatf("n_value %0d: divisor_count %0d, want %0d",
							head.number, divisor_count, head.count));
				end
			end
			waiting <= counts_due.size();
		end
	end

endmodule

@@ tb/distinct_prime_divisor_counter_unit_test.sv @@
`timescale 1ns / 1ps

module distinct_prime_divisor_counter_unit_test;
	import dpdc_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   done;
	logic [VALUE_WIDTH-1:0] n_value;
	logic [COUNT_WIDTH-1:0] divisor_count;
	int                     mismatches;
	int                     waiting;
	int                     idle_pct;

	int unsigned small_primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 251};
	int unsigned picked_values [20] = '{
		0, 1, 2, 3, 4, 6, 8, 9, 12, 30030, 60060, 65535, 65534, 65521, 63001,
		65025, 32768, 32749, 49152, 64507
	};
	int unsigned phase_idle [4] = '{0, 60, 0, 19};

	distinct_prime_divisor_counter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.n_value       (n_value),
		.divisor_count (divisor_count)
	);

	prime_count_watch watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.n_value       (n_value),
		.divisor_count (divisor_count),
		.mismatches    (mismatches),
		.waiting       (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [VALUE_WIDTH-1:0] random_number();
		int unsigned pick;
		int unsigned product;
		int unsigned factor;
		pick = $urandom_range(99);
		if (pick < 40)
			return VALUE_WIDTH'($urandom_range(65535));
		if (pick < 65)
			return VALUE_WIDTH'($urandom_range(255));
		if (pick < 92) begin
			product = 1;
			repeat ($urandom_range(1, 8)) begin
				factor = small_primes[$urandom_range(9)];
				if (product * factor <= 65535)
					product = product * factor;
			end
			return VALUE_WIDTH'(product);
		end
		return VALUE_WIDTH'(picked_values[$urandom_range(19)]);
	endfunction

	task automatic idle_gap();
		int unsigned gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = ($urandom_range(7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4);
			repeat (gap) begin
				start   <= 1'b0;
				n_value <= VALUE_WIDTH'($urandom);
				@(posedge clk);
			end
		end
	endtask

	task automatic send_number(input logic [VALUE_WIDTH-1:0] value);
		idle_gap();
		start   <= 1'b1;
		n_value <= value;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		n_value  = '0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (picked_values[i])
			send_number(VALUE_WIDTH'(picked_values[i]));
		drain();

		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			repeat (25)
				send_number(random_number());
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dpdc_pkg.sv
rtl/distinct_prime_divisor_counter_unit.sv
rtl/dpdc_chk.sv
tb/prime_count_watch.sv
tb/distinct_prime_divisor_counter_unit_test.sv
